FILE: rtl/nfsa_pkg.sv
// Shared types and constants of the next-fit slot allocator.
`default_nettype none

package nfsa_pkg;

    // Live-map word width and the bits that address a slot inside a word.
    localparam int WORD_W = 64;
    localparam int BIT_W = 6;

    localparam int COUNT_W = 13;
    localparam int INDEX_W = 12;
    localparam int BYTES_W = 32;
    localparam int TOTAL_BYTES_W = 44;

    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_BYTES = 8'd1;

    localparam logic [COUNT_W-1:0] SLOT_COUNT_RESET = 13'd4096;
    localparam logic [BYTES_W-1:0] SLOT_BYTES_RESET = 32'd1;

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_ALLOCATED = 2'd0,
        ST_FULL      = 2'd1,
        ST_RELEASED  = 2'd2,
        ST_IGNORED   = 2'd3
    } status_t;

    typedef struct packed {
        op_t                op;
        logic [INDEX_W-1:0] slot_index;
    } req_t;

    typedef struct packed {
        status_t                  status;
        logic [INDEX_W-1:0]       granted_slot;
        logic [COUNT_W-1:0]       live_slots;
        logic [TOTAL_BYTES_W-1:0] live_bytes;
    } rsp_t;

    // Outcome of searching one live-map word for a free slot.
    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] bit_pos;
    } scan_res_t;

endpackage

`default_nettype wire

FILE: rtl/next_fit_slot_allocator_core.sv
// Next-fit slot allocator: live bitmap in RAM, word-at-a-time search from a rotating hint.
//
// Requests arrive on req (valid/ready): op allocates the next free slot or releases
// slot_index. Each request yields exactly one result on rsp (valid/ready) with a
// status, the granted slot, the live slot count and the live byte total.
// Registers are written on the cfg channel (index 0 slot count, index 1 bytes per
// slot), which is always ready; write them only while the block is idle.
// After reset the live map is cleared one 64-slot word per cycle; req_ready stays
// low meanwhile.
// One request is worked on at a time. A release reads the map word of its slot; a
// request that reads no map word (zero slot count, index out of range) skips that
// read. An allocate reads one map word per cycle from the hint up to the slot count
// and then from slot 0 up to the hint, searching at most ceil(count/64) + 1 words,
// 65 for 4096 slots. The single read port of the map RAM sets that pace. The next
// request can be taken in the same cycle that the result shows.
// The result sits in an output register; the next request is taken while it waits,
// and a request whose result is due while the receiver stalls holds until the
// register frees.
`default_nettype none

module next_fit_slot_allocator_core #(
    parameter int SLOTS = 4096
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               req_valid,
    output logic                                    req_ready,
    input  wire nfsa_pkg::req_t                     req,
    output logic                                    rsp_valid,
    input  wire logic                               rsp_ready,
    output nfsa_pkg::rsp_t                          rsp,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [nfsa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [nfsa_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int WORD_W = nfsa_pkg::WORD_W;
    localparam int BIT_W = nfsa_pkg::BIT_W;
    localparam int WORDS = (SLOTS + WORD_W - 1) / WORD_W;
    localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PW = AW + BIT_W;
    localparam int XW = (PW + 1 > nfsa_pkg::COUNT_W) ? PW + 1 : nfsa_pkg::COUNT_W;
    localparam int MW = XW + nfsa_pkg::BYTES_W;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_RCHK  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [AW-1:0] word_reg, word_next;
    logic [PW-1:0] lo_reg, lo_next;
    logic [PW-1:0] last_reg, last_next;
    logic [PW-1:0] start_reg, start_next;
    logic phase_reg, phase_next;
    logic [BIT_W-1:0] bit_reg, bit_next;
    logic [PW-1:0] hint_reg, hint_next;
    logic [XW-1:0] total_reg, total_next;
    logic [PW-1:0] granted_reg, granted_next;
    nfsa_pkg::status_t status_reg, status_next;
    logic [nfsa_pkg::COUNT_W-1:0] count_reg;
    logic [nfsa_pkg::BYTES_W-1:0] bytes_reg;
    logic rsp_valid_reg, rsp_valid_next;
    nfsa_pkg::rsp_t rsp_reg, rsp_next;

    logic ram_we;
    logic [AW-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    logic [XW-1:0] cnt;
    logic [PW-1:0] start_pos;
    logic [XW-1:0] req_idx_x;
    logic [PW-1:0] slot_pos;
    logic [XW-1:0] slot_inc;
    logic [XW-1:0] granted_x;
    logic [MW-1:0] product;
    logic rsp_load;
    nfsa_pkg::scan_res_t scan_res;

    nfsa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_live_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    nfsa_scan #(
        .PW (PW)
    ) u_scan (
        .word_bits (ram_rdata),
        .word_addr (word_reg),
        .lo        (lo_reg),
        .last      (last_reg),
        .res       (scan_res)
    );

    // Slot counts above the map size saturate to it.
    assign cnt = (XW'(count_reg) > XW'(SLOTS)) ? XW'(SLOTS) : XW'(count_reg);
    assign start_pos = (XW'(hint_reg) < cnt) ? hint_reg : '0;
    assign req_idx_x = XW'(req.slot_index);
    assign slot_pos = {word_reg, scan_res.bit_pos};
    assign slot_inc = XW'(slot_pos) + XW'(1);
    assign granted_x = XW'(granted_reg);
    assign product = MW'(total_reg) * MW'(bytes_reg);

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;
    assign cfg_ready = 1'b1;
    assign rsp_load = (state_reg == S_DONE) && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        state_next = state_reg;
        clr_next = clr_reg;
        word_next = word_reg;
        lo_next = lo_reg;
        last_next = last_reg;
        start_next = start_reg;
        phase_next = phase_reg;
        bit_next = bit_reg;
        hint_next = hint_reg;
        total_next = total_reg;
        granted_next = granted_reg;
        status_next = status_reg;
        ram_we = 1'b0;
        ram_waddr = word_reg;
        ram_wdata = ram_rdata;
        ram_raddr = word_reg;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    granted_next = '0;
                    if (req.op == nfsa_pkg::OP_ALLOC)
                    begin
                        if (cnt == '0)
                        begin
                            status_next = nfsa_pkg::ST_FULL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            start_next = start_pos;
                            lo_next = start_pos;
                            last_next = PW'(cnt - XW'(1));
                            phase_next = 1'b0;
                            word_next = start_pos[PW-1:BIT_W];
                            ram_raddr = start_pos[PW-1:BIT_W];
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        if (req_idx_x < cnt)
                        begin
                            word_next = req_idx_x[PW-1:BIT_W];
                            ram_raddr = req_idx_x[PW-1:BIT_W];
                            bit_next = req.slot_index[BIT_W-1:0];
                            state_next = S_RCHK;
                        end
                        else
                        begin
                            status_next = nfsa_pkg::ST_IGNORED;
                            state_next = S_DONE;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_res.found)
                begin
                    ram_we = 1'b1;
                    ram_wdata = ram_rdata | (WORD_W'(1) << scan_res.bit_pos);
                    total_next = total_reg + XW'(1);
                    granted_next = slot_pos;
                    hint_next = (slot_inc < cnt) ? PW'(slot_inc) : '0;
                    status_next = nfsa_pkg::ST_ALLOCATED;
                    state_next = S_DONE;
                end
                else if (word_reg == last_reg[PW-1:BIT_W])
                begin
                    // End of the range: wrap to slot 0 and search below the start, else (wrapped, or start 0) full.
                    if (!phase_reg && (start_reg != '0))
                    begin
                        phase_next = 1'b1;
                        lo_next = '0;
                        last_next = start_reg - PW'(1);
                        word_next = '0;
                        ram_raddr = '0;
                    end
                    else
                    begin
                        status_next = nfsa_pkg::ST_FULL;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    // Read the following word now so that one word is searched per cycle.
                    word_next = word_reg + AW'(1);
                    ram_raddr = word_reg + AW'(1);
                end
            end
            S_RCHK:
            begin
                if (ram_rdata[bit_reg])
                begin
                    ram_we = 1'b1;
                    ram_wdata = ram_rdata & ~(WORD_W'(1) << bit_reg);
                    total_next = total_reg - XW'(1);
                    status_next = nfsa_pkg::ST_RELEASED;
                end
                else
                begin
                    status_next = nfsa_pkg::ST_IGNORED;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next = rsp_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
            rsp_next.status = status_reg;
            rsp_next.granted_slot = granted_x[nfsa_pkg::INDEX_W-1:0];
            rsp_next.live_slots = total_reg[nfsa_pkg::COUNT_W-1:0];
            rsp_next.live_bytes = product[nfsa_pkg::TOTAL_BYTES_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            hint_reg <= '0;
            total_reg <= '0;
            rsp_valid_reg <= 1'b0;
            count_reg <= nfsa_pkg::SLOT_COUNT_RESET;
            bytes_reg <= nfsa_pkg::SLOT_BYTES_RESET;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            hint_reg <= hint_next;
            total_reg <= total_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == nfsa_pkg::CFG_SLOT_COUNT)
                begin
                    count_reg <= cfg_data[nfsa_pkg::COUNT_W-1:0];
                end
                else if (cfg_index == nfsa_pkg::CFG_SLOT_BYTES)
                begin
                    bytes_reg <= cfg_data[nfsa_pkg::BYTES_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        lo_reg <= lo_next;
        last_reg <= last_next;
        start_reg <= start_next;
        phase_reg <= phase_next;
        bit_reg <= bit_next;
        granted_reg <= granted_next;
        status_reg <= status_next;
        rsp_reg <= rsp_next;
    end

endmodule

`default_nettype wire

FILE: rtl/nfsa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module nfsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                                          clk,
    input  wire logic                                          we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                              wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/nfsa_scan.sv
// Search of one live-map word for the lowest free slot inside a slot range.
`default_nettype none

module nfsa_scan #(
    parameter int PW = 12
) (
    input  wire logic [nfsa_pkg::WORD_W-1:0]   word_bits,
    input  wire logic [PW-nfsa_pkg::BIT_W-1:0] word_addr,
    input  wire logic [PW-1:0]                 lo,
    input  wire logic [PW-1:0]                 last,
    output nfsa_pkg::scan_res_t                res
);

    localparam int WORD_W = nfsa_pkg::WORD_W;
    localparam int BIT_W = nfsa_pkg::BIT_W;

    logic [WORD_W-1:0] lo_mask;
    logic [WORD_W-1:0] hi_mask;
    logic [WORD_W-1:0] avail;

    // The word being searched never lies below the word of lo or above the word of last.
    always_comb
    begin
        lo_mask = {WORD_W{1'b1}};
        hi_mask = {WORD_W{1'b1}};
        if (word_addr == lo[PW-1:BIT_W])
        begin
            lo_mask = {WORD_W{1'b1}} << lo[BIT_W-1:0];
        end
        if (word_addr == last[PW-1:BIT_W])
        begin
            hi_mask = {WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - last[BIT_W-1:0]);
        end
        avail = ~word_bits & lo_mask & hi_mask;
    end

    // Priority encoder: the lowest free bit wins.
    always_comb
    begin
        res.found = 1'b0;
        res.bit_pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (avail[i])
            begin
                res.found = 1'b1;
                res.bit_pos = BIT_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/nfsa_checker.sv
// Port-level checks of the slot allocator, bound to its top level.
`default_nettype none

module nfsa_checker #(
    parameter int SLOTS = 4096
) (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           req_valid,
    input wire logic           req_ready,
    input wire logic           rsp_valid,
    input wire logic           rsp_ready,
    input wire nfsa_pkg::rsp_t rsp
);

    // A result that is stalled keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

    // Requests are worked on one at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
    else $error("request taken while the previous one is in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != nfsa_pkg::ST_ALLOCATED) |-> rsp.granted_slot == '0)
    else $error("granted slot set on a result that grants nothing");

    // A grant leaves at least one slot live, checked for maps under 8192 slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == nfsa_pkg::ST_ALLOCATED)
            |-> (SLOTS >= 8192) || (rsp.live_slots != '0))
    else $error("allocation reported with no live slots");

endmodule

bind next_fit_slot_allocator_core nfsa_checker #(
    .SLOTS (SLOTS)
) u_nfsa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire

FILE: tb/tb_next_fit_slot_allocator_core.sv
// Self-checking testbench for the next-fit slot allocator core.
`timescale 1ns / 1ps

module tb_next_fit_slot_allocator_core;

    localparam int MAP_SLOTS = 4096;
    localparam int PHASES = 12;
    localparam int PHASE_ITEMS = 86;
    localparam int SINK_HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 80;

    // Register indexes the block does not decode.
    localparam logic [nfsa_pkg::CFG_IDX_W-1:0] REG_UNUSED = 8'd2;
    localparam logic [nfsa_pkg::CFG_IDX_W-1:0] REG_TOP = 8'hFF;

    localparam nfsa_pkg::rsp_t UNPINNED = '0;

    typedef enum logic {
        ROW_REQUEST = 1'b0,
        ROW_WRITE   = 1'b1
    } row_kind_t;

    typedef struct packed {
        row_kind_t                        kind;
        logic [nfsa_pkg::CFG_IDX_W-1:0]   reg_index;
        logic [nfsa_pkg::CFG_DATA_W-1:0]  reg_value;
        nfsa_pkg::op_t                    op;
        logic [nfsa_pkg::INDEX_W-1:0]     slot;
        logic                             pinned;
        nfsa_pkg::rsp_t                   want;
    } step_t;

    typedef struct packed {
        logic           pinned;
        nfsa_pkg::rsp_t value;
    } pinned_t;

    localparam int DIRECTED_ROWS = 28;

    localparam step_t DIRECTED [DIRECTED_ROWS] = '{
        '{ROW_REQUEST, REG_UNUSED, 32'd0, nfsa_pkg::OP_ALLOC, 12'd0, 1'b1,
          '{nfsa_pkg::ST_ALLOCATED, 12'd0, 13'd1, 44'd1}},
        '{ROW_REQUEST, REG_UNUSED, 32'd0, nfsa_pkg::OP_RELEASE, 12'd4095, 1'b1,
          '{nfsa_pkg::ST_IGNORED, 12'd0, 13'd1, 44'd1}},
        '{ROW_REQUEST, REG_UNUSED, 32'd0, nfsa_pkg::OP_RELEASE, 12'd0, 1'b1,
          '{nfsa_pkg::ST_RELEASED, 12'd0, 13'd0, 44'd0}},
        '{ROW_REQUEST, REG_UNUSED, 32'd0, nfsa_pkg::OP_RELEASE, 12'd0, 1'b1,
          '{nfsa_pkg::ST_IGNORED, 12'd0, 13'd0, 44'd0}},
        '{ROW_WRITE, nfsa_pkg::CFG_SLOT_COUNT, 32'd0, nfsa_pkg::OP_ALLOC, 12'd0, 1'b0,
          UNPINNED},
        '{ROW_REQUEST, REG_UNUSED, 32'd0, nfsa_pkg::OP_ALLOC, 12'd4095, 1'b1,
          '{nfsa_pkg::ST_FULL, 12'd0, 13'd0, 44'd0}},
        '{ROW_REQUEST, REG_UNUSED, 32'd0, nfsa_pkg::OP_RELEASE, 12'd0, 1'b1,
          '{nfsa_pkg::ST_IGNORED, 12'd0, 13'd0, 44'd0}},
        '{ROW_WRITE, nfsa_pkg::CFG_SLOT_COUNT, 32'd2, nfsa_pkg::OP_ALLOC, 12'd0, 1'b0,
          UNPINNED},
        '{ROW_WRITE, nfsa_pkg::CFG_SLOT_BYTES, 32'hFFFF_FFFF, nfsa_pkg::OP_ALLOC, 12'd0,
          1'b0, UNPINNED},
        '{ROW_REQUEST, REG_UNUSED, 32'd0, nfsa_pkg::OP_ALLOC, 12'd0, 1'b0, UNPINNED},
        '{ROW_REQUEST, REG_UNUSED, 32'd0, nfsa_pkg::OP_ALLOC, 12'd0, 1'b0, UNPINNED},
        '{ROW_REQUEST, REG_UNUSED, 32'd0, nfsa_pkg::OP_ALLOC, 12'd0, 1'b1,
          '{nfsa_pkg::ST_FULL, 12'd0, 13'd2, 44'h1_FFFF_FFFE}},
        '{ROW_WRITE, nfsa_pkg::CFG_SLOT_COUNT, 32'd1, nfsa_pkg::OP_ALLOC, 12'd0, 1'b0,
          UNPINNED},
        '{ROW_REQUEST, REG_UNUSED, 32'd0, nfsa_pkg::OP_RELEASE, 12'd1, 1'b1,
          '{nfsa_pkg::ST_IGNORED, 12'd0, 13'd2, 44'h1_FFFF_FFFE}},
        '{ROW_REQUEST, REG_UNUSED, 32'd0, nfsa_pkg::OP_ALLOC, 12'd0, 1'b1,
          '{nfsa_pkg::ST_FULL, 12'd0, 13'd2, 44'h1_FFFF_FFFE}},
        '{ROW_REQUEST, REG_UNUSED, 32'd0, nfsa_pkg::OP_RELEASE, 12'd0, 1'b1,
          '{nfsa_pkg::ST_RELEASED, 12'd0, 13'd1, 44'h0_FFFF_FFFF}},
        '{ROW_REQUEST, REG_UNUSED, 32'd0, nfsa_pkg::OP_ALLOC, 12'd0, 1'b0, UNPINNED},
        '{ROW_WRITE, REG_UNUSED, 32'hFFFF_FFFF, nfsa_pkg::OP_ALLOC, 12'd0, 1'b0, UNPINNED},
        '{ROW_WRITE, REG_TOP, 32'd0, nfsa_pkg::OP_ALLOC, 12'd0, 1'b0, UNPINNED},
        '{ROW_WRITE, nfsa_pkg::CFG_SLOT_COUNT, 32'h0000_1FFF, nfsa_pkg::OP_ALLOC, 12'd0,
          1'b0, UNPINNED},
        '{ROW_REQUEST, REG_UNUSED, 32'd0, nfsa_pkg::OP_RELEASE, 12'd4095, 1'b0, UNPINNED},
        '{ROW_REQUEST, REG_UNUSED, 32'd0, nfsa_pkg::OP_ALLOC, 12'd0, 1'b0, UNPINNED},
        '{ROW_REQUEST, REG_UNUSED, 32'd0, nfsa_pkg::OP_ALLOC, 12'd0, 1'b0, UNPINNED},
        '{ROW_REQUEST, REG_UNUSED, 32'd0, nfsa_pkg::OP_RELEASE, 12'd1, 1'b0, UNPINNED},
        '{ROW_WRITE, nfsa_pkg::CFG_SLOT_COUNT, 32'hFFFF_E040, nfsa_pkg::OP_ALLOC, 12'd0,
          1'b0, UNPINNED},
        '{ROW_WRITE, nfsa_pkg::CFG_SLOT_BYTES, 32'd0, nfsa_pkg::OP_ALLOC, 12'd0, 1'b0,
          UNPINNED},
        '{ROW_REQUEST, REG_UNUSED, 32'd0, nfsa_pkg::OP_ALLOC, 12'd0, 1'b0, UNPINNED},
        '{ROW_REQUEST, REG_UNUSED, 32'd0, nfsa_pkg::OP_RELEASE, 12'd2, 1'b0, UNPINNED}
    };

    logic                            clk;
    logic                            rst_n;
    logic                            req_valid;
    logic                            req_ready;
    nfsa_pkg::req_t                  req;
    logic                            rsp_valid;
    logic                            rsp_ready;
    nfsa_pkg::rsp_t                  rsp;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [nfsa_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [nfsa_pkg::CFG_DATA_W-1:0] cfg_data;

    // Mirror of the allocator state, advanced on every accepted request and register write.
    bit                              mirror_busy [MAP_SLOTS] = '{default: 1'b0};
    int                              search_hint = 0;
    int                              live_total = 0;
    logic [nfsa_pkg::COUNT_W-1:0]    reg_slot_count = nfsa_pkg::SLOT_COUNT_RESET;
    logic [nfsa_pkg::BYTES_W-1:0]    reg_slot_bytes = nfsa_pkg::SLOT_BYTES_RESET;

    nfsa_pkg::rsp_t                  due_results [$];
    pinned_t                         typed_results [$];
    int                              mismatches = 0;
    int                              stall_cycles = 0;
    int                              src_idle_pct = 0;
    int                              sink_idle_pct = 0;
    bit                              hold_armed = 1'b0;
    bit                              hold_done = 1'b0;

    next_fit_slot_allocator_core #(
        .SLOTS(MAP_SLOTS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int active_span();
        return (reg_slot_count > MAP_SLOTS) ? MAP_SLOTS : int'(reg_slot_count);
    endfunction

    // Next-fit search from the hint, or release of one live slot in range.
    function automatic nfsa_pkg::rsp_t serve_request(input nfsa_pkg::req_t item);
        int             span;
        int             cand;
        int             n;
        logic [63:0]    product;
        nfsa_pkg::rsp_t res;
        span = active_span();
        res = '0;
        if (item.op == nfsa_pkg::OP_ALLOC)
        begin
            res.status = nfsa_pkg::ST_FULL;
            cand = (search_hint < span) ? search_hint : 0;
            for (n = 0; n < span; n++)
            begin
                if (!mirror_busy[cand])
                begin
                    mirror_busy[cand] = 1'b1;
                    live_total++;
                    search_hint = (cand + 1 < span) ? cand + 1 : 0;
                    res.status = nfsa_pkg::ST_ALLOCATED;
                    res.granted_slot = cand[nfsa_pkg::INDEX_W-1:0];
                    break;
                end
                cand = (cand + 1 < span) ? cand + 1 : 0;
            end
        end
        else
        begin
            res.status = nfsa_pkg::ST_IGNORED;
            if (int'(item.slot_index) < span && mirror_busy[item.slot_index])
            begin
                mirror_busy[item.slot_index] = 1'b0;
                live_total--;
                res.status = nfsa_pkg::ST_RELEASED;
            end
        end
        product = 64'(live_total) * 64'(reg_slot_bytes);
        res.live_slots = live_total[nfsa_pkg::COUNT_W-1:0];
        res.live_bytes = product[nfsa_pkg::TOTAL_BYTES_W-1:0];
        return res;
    endfunction

    task automatic check_field(input string field, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    // Monitor: all three channels are sampled at the clock edge.
    always @(posedge clk)
    begin
        nfsa_pkg::rsp_t want;
        pinned_t        pin;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == nfsa_pkg::CFG_SLOT_COUNT)
                    reg_slot_count = cfg_data[nfsa_pkg::COUNT_W-1:0];
                else if (cfg_index == nfsa_pkg::CFG_SLOT_BYTES)
                    reg_slot_bytes = cfg_data;
            end
            if (req_valid && req_ready)
            begin
                want = serve_request(req);
                pin = typed_results.pop_front();
                due_results.push_back(pin.pinned ? pin.value : want);
            end
            if (rsp_valid && rsp_ready)
            begin
                if (due_results.size() == 0)
                begin
                    $display("%0t: result with none expected, actual status %0d slot %0d",
                             $time, rsp.status, rsp.granted_slot);
                    mismatches++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("status", want.status, rsp.status);
                    check_field("granted_slot", want.granted_slot, rsp.granted_slot);
                    check_field("live_slots", want.live_slots, rsp.live_slots);
                    check_field("live_bytes", want.live_bytes, rsp.live_bytes);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Result receiver; one long hold-off when armed lets the block back up.
    initial
    begin
        rsp_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_armed && !hold_done)
            begin
                rsp_ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            rsp_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    task automatic send_request(input nfsa_pkg::req_t item, input logic pinned,
                                input nfsa_pkg::rsp_t value);
        pinned_t pin;
        pin.pinned = pinned;
        pin.value = value;
        typed_results.push_back(pin);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    // Holds off new requests until every accepted request has produced its result.
    task automatic wait_for_drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [nfsa_pkg::CFG_IDX_W-1:0] index,
                             input logic [nfsa_pkg::CFG_DATA_W-1:0] value);
        wait_for_drain();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0:
            begin
                src_idle_pct = 35;
                sink_idle_pct = 87;
            end
            1:
            begin
                src_idle_pct = 87;
                sink_idle_pct = 35;
            end
            default:
            begin
                src_idle_pct = 0;
                sink_idle_pct = 0;
            end
        endcase
    endtask

    initial
    begin
        nfsa_pkg::req_t               item;
        logic [nfsa_pkg::COUNT_W-1:0] count_val;
        logic [nfsa_pkg::BYTES_W-1:0] bytes_val;
        int                           span;
        int                           alloc_pct;
        rst_n <= 1'b0;
        req_valid <= 1'b0;
        req <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        set_idling(0);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (DIRECTED[i].kind == ROW_WRITE)
                write_reg(DIRECTED[i].reg_index, DIRECTED[i].reg_value);
            else
            begin
                item.op = DIRECTED[i].op;
                item.slot_index = DIRECTED[i].slot;
                send_request(item, DIRECTED[i].pinned, DIRECTED[i].want);
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            set_idling(p / 4);
            case ($urandom_range(0, 11))
                0: count_val = 13'd0;
                1: count_val = 13'd1;
                2: count_val = 13'd2;
                3: count_val = 13'd64;
                4: count_val = 13'd65;
                5: count_val = 13'd4096;
                6: count_val = 13'($urandom_range(4097, 8191));
                default: count_val = 13'($urandom_range(3, 130));
            endcase
            case ($urandom_range(0, 5))
                0: bytes_val = 32'd1;
                1: bytes_val = 32'hFFFF_FFFF;
                2: bytes_val = 32'd0;
                default: bytes_val = $urandom;
            endcase
            // The upper data bits above the count field are don't-care noise.
            write_reg(nfsa_pkg::CFG_SLOT_COUNT, {19'($urandom), count_val});
            write_reg(nfsa_pkg::CFG_SLOT_BYTES, bytes_val);
            if (p == 8)
                hold_armed = 1'b1;
            alloc_pct = $urandom_range(45, 70);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                span = active_span();
                item.slot_index = 12'($urandom);
                if ($urandom_range(0, 99) < alloc_pct)
                    item.op = nfsa_pkg::OP_ALLOC;
                else
                begin
                    item.op = nfsa_pkg::OP_RELEASE;
                    // Mostly aim releases at slots in range so live ones get freed.
                    if (span > 0 && $urandom_range(0, 99) < 80)
                        item.slot_index = 12'($urandom_range(0, span - 1));
                end
                send_request(item, 1'b0, UNPINNED);
            end
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
